// ----- src/value_frequency_counter_core_macros.svh -----
// Assertion macros for the value frequency counter.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef VALUE_FREQUENCY_COUNTER_CORE_MACROS_SVH
`define VALUE_FREQUENCY_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VFC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/vfc_pkg.sv -----
// Shared constants for the value frequency counter: operation codes,
// count widths and stream payload layout. No dependencies.
`default_nettype none

package vfc_pkg;

  localparam int unsigned CNT_W       = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned DIST_W      = 9;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 144;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (4 * CNT_W + DIST_W + 2);

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

// ----- src/vfc_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read
// data. Holds the value/count table; no dependencies.
`default_nettype none

module vfc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/value_frequency_counter_core.sv -----
// Value frequency counter, top level: stream ports, scan/update sequencer
// and running statistics. Depends on vfc_pkg, vfc_ram and the macro header.
//
// Usage:
//   Requests enter on the s_axis channel: tdata[0] is the operation (0 record
//   an occurrence, 1 query the count), tdata[32:1] the signed value. Each
//   request yields exactly one result on the m_axis channel carrying the
//   value's count plus total, distinct and most-frequent statistics.
//   The table lives in a one-read, one-write RAM. A request is matched by
//   reading the used entries one per cycle, in order, until a hit; a record
//   then updates the hit entry in place, appends a new entry if there is
//   room, or is dropped when the table is full. One request is in work at a
//   time: a new request is accepted only once the sequencer is idle again.
//   The result register decouples the sides: the next request is accepted
//   while the previous result waits. If the receiver stalls, a finished
//   result holds in the sequencer until the output register frees up.
//   Reset clears the statistics and the fill count; table contents need no
//   clearing since only entries below the fill count are ever read.
`default_nettype none
`include "value_frequency_counter_core_macros.svh"

module value_frequency_counter_core
  import vfc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // tdata: op[0], value[32:1], zero pad[39:33]
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: value_count[31:0], found[32], table_full_drop[33],
  //        total_count[65:34], distinct_count[74:66], top_value[106:75],
  //        top_times[138:107], zero pad[143:139]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WORD_W = VALUE_BITS + CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESULT
  } state_e;

  state_e                  state_q, state_d;
  logic                    op_q, op_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [USED_W-1:0]       scan_q, scan_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic [CNT_W-1:0]        hit_times_q, hit_times_d;
  logic [USED_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic [VALUE_BITS-1:0]   best_val_q, best_val_d;
  logic [CNT_W-1:0]        best_times_q, best_times_d;
  logic [CNT_W-1:0]        res_cnt_q, res_cnt_d;
  logic                    res_drop_q, res_drop_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]  m_data_q, m_data_d;

  logic signed [IN_VALUE_W-1:0] in_value_s;
  logic                    issue;
  logic                    match;
  logic                    room;
  logic [VALUE_BITS-1:0]   rd_val;
  logic [CNT_W-1:0]        rd_times;
  logic [CNT_W-1:0]        times_inc;
  logic [CNT_W-1:0]        dec_cnt;
  logic                    dec_drop;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;

  vfc_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (WORD_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_value_s = s_axis_tdata[IN_VALUE_W:1];
  assign rd_val     = ram_rdata[VALUE_BITS-1:0];
  assign rd_times   = ram_rdata[VALUE_BITS +: CNT_W];
  assign issue      = (state_q == S_SCAN) && (scan_q < used_q);
  assign match      = cmp_vld_q && (rd_val == val_q);
  assign room       = used_q < USED_W'(TABLE_ENTRIES);
  assign times_inc  = (hit_times_q == CNT_MAX) ? hit_times_q : hit_times_q + 1'b1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    scan_d       = scan_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_times_d  = hit_times_q;
    used_d       = used_q;
    total_d      = total_q;
    best_val_d   = best_val_q;
    best_times_d = best_times_q;
    res_cnt_d    = res_cnt_q;
    res_drop_d   = res_drop_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    ram_we       = 1'b0;
    ram_waddr    = hit_idx_q;
    ram_wdata    = {times_inc, val_q};
    dec_cnt      = '0;
    dec_drop     = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tdata[0];
          val_d   = VALUE_BITS'(in_value_s);
          scan_d  = '0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // read one entry per cycle, compare it the cycle after
        if (issue) begin
          scan_d = scan_q + 1'b1;
        end
        cmp_vld_d = issue;
        cmp_idx_d = scan_q[IDX_W-1:0];
        if (match) begin
          hit_d       = 1'b1;
          hit_idx_d   = cmp_idx_q;
          hit_times_d = rd_times;
          cmp_vld_d   = 1'b0;
          state_d     = S_DECIDE;
        end else if (!issue && !cmp_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (op_q == OP_QUERY) begin
          dec_cnt = hit_q ? hit_times_q : '0;
        end else begin
          if (total_q != CNT_MAX) begin
            total_d = total_q + 1'b1;
          end
          if (hit_q) begin
            ram_we  = 1'b1;
            dec_cnt = times_inc;
          end else if (room) begin
            ram_we    = 1'b1;
            ram_waddr = used_q[IDX_W-1:0];
            ram_wdata = {CNT_W'(1), val_q};
            used_d    = used_q + 1'b1;
            dec_cnt   = CNT_W'(1);
          end else begin
            dec_drop = 1'b1;
          end
          // strictly greater only, so ties keep the earlier value
          if (!dec_drop && (dec_cnt > best_times_q)) begin
            best_times_d = dec_cnt;
            best_val_d   = val_q;
          end
        end
        res_cnt_d  = dec_cnt;
        res_drop_d = dec_drop;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {OUT_PAD_W'(0), best_times_q, CNT_W'(signed'(best_val_q)),
                       DIST_W'(used_q), total_q, res_drop_q, hit_q, res_cnt_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmp_vld_q    <= 1'b0;
      used_q       <= '0;
      total_q      <= '0;
      best_val_q   <= '0;
      best_times_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmp_vld_q    <= cmp_vld_d;
      used_q       <= used_d;
      total_q      <= total_d;
      best_val_q   <= best_val_d;
      best_times_q <= best_times_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    val_q       <= val_d;
    scan_q      <= scan_d;
    cmp_idx_q   <= cmp_idx_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_times_q <= hit_times_d;
    res_cnt_q   <= res_cnt_d;
    res_drop_q  <= res_drop_d;
    m_data_q    <= m_data_d;
  end

  `VFC_ASSERT_IMP(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= USED_W'(TABLE_ENTRIES), "fill count beyond table size")
  `VFC_ASSERT_IMP(a_write_in_decide, clk_i, rst_ni, ram_we, state_q == S_DECIDE, "table write outside update step")
  `VFC_ASSERT_IMP(a_idle_no_compare, clk_i, rst_ni, s_axis_tready, !cmp_vld_q, "compare pending while accepting")
  `VFC_ASSERT_NXT(a_best_monotonic, clk_i, rst_ni, 1'b1, best_times_q >= $past(best_times_q), "top count decreased")

endmodule

`default_nettype wire

// ----- tb/value_frequency_counter_core_tb.sv -----
// Self-checking testbench for value_frequency_counter_core: drives record and
// query requests on the input stream and checks every result against a
// tally model kept in the bench. Depends on vfc_pkg and the core RTL.
module value_frequency_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vfc_pkg::*;

  localparam int TBL_DEPTH    = 256;
  localparam int POOL_SIZE    = 40;
  localparam int ITEM_TARGET  = 1950;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = TBL_DEPTH + 16;

  typedef struct packed {
    logic [CNT_W-1:0]      times;
    logic                  found;
    logic                  dropped;
    logic [CNT_W-1:0]      total;
    logic [DIST_W-1:0]     distinct;
    logic [IN_VALUE_W-1:0] mode_value;
    logic [CNT_W-1:0]      mode_times;
  } tally_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Bench copy of the counter state
  logic [IN_VALUE_W-1:0] tbl_value [TBL_DEPTH];
  logic [CNT_W-1:0]      tbl_times [TBL_DEPTH];
  int                    tbl_used;
  logic [CNT_W-1:0]      records_total;
  logic [IN_VALUE_W-1:0] mode_value;
  logic [CNT_W-1:0]      mode_times;

  tally_t                pending_tallies [$];
  logic [IN_VALUE_W-1:0] value_pool [POOL_SIZE];
  int unsigned           mismatch_count;
  int unsigned           items_sent;
  bit                    idle_en;
  bit                    long_hold_req;

  value_frequency_counter_core #(
    .TABLE_ENTRIES(TBL_DEPTH),
    .VALUE_BITS   (IN_VALUE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("[value_frequency_counter_core] ERROR");
    $finish;
  end

  function automatic int find_slot(input logic [IN_VALUE_W-1:0] val);
    for (int k = 0; k < tbl_used; k++) begin
      if (tbl_value[k] == val) return k;
    end
    return -1;
  endfunction

  function automatic tally_t predict_tally(input logic op, input logic [IN_VALUE_W-1:0] val);
    tally_t r;
    int     slot;
    slot = find_slot(val);
    r = '0;
    if (op == OP_RECORD) begin
      if (records_total != CNT_MAX) records_total++;
      if (slot >= 0) begin
        if (tbl_times[slot] != CNT_MAX) tbl_times[slot]++;
        r.times = tbl_times[slot];
      end else if (tbl_used < TBL_DEPTH) begin
        tbl_value[tbl_used] = val;
        tbl_times[tbl_used] = 1;
        tbl_used++;
        r.times = 1;
      end else begin
        r.dropped = 1'b1;
      end
      // strictly greater only: a tie keeps the earlier value
      if (!r.dropped && r.times > mode_times) begin
        mode_times = r.times;
        mode_value = val;
      end
    end else if (slot >= 0) begin
      r.times = tbl_times[slot];
    end
    r.found      = (slot >= 0);
    r.total      = records_total;
    r.distinct   = DIST_W'(tbl_used);
    r.mode_value = mode_value;
    r.mode_times = mode_times;
    return r;
  endfunction

  // Mostly short, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(40, 300);
  endfunction

  task automatic send_request(input logic op, input logic [IN_VALUE_W-1:0] val);
    int gap;
    gap = (idle_en && $urandom_range(0, 1) == 1) ? idle_cycles() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_VALUE_W - 1){1'b0}}, val, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_tallies.push_back(predict_tally(op, val));
    items_sent++;
  endtask

  task automatic compare_field(input string what, input logic [CNT_W-1:0] exp_v,
                               input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tally_t exp_t;
    tally_t got_t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_t.times      = m_axis_tdata[31:0];
      got_t.found      = m_axis_tdata[32];
      got_t.dropped    = m_axis_tdata[33];
      got_t.total      = m_axis_tdata[65:34];
      got_t.distinct   = m_axis_tdata[74:66];
      got_t.mode_value = m_axis_tdata[106:75];
      got_t.mode_times = m_axis_tdata[138:107];
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_t = pending_tallies.pop_front();
        compare_field("value_count", exp_t.times, got_t.times);
        compare_field("found", exp_t.found, got_t.found);
        compare_field("table_full_drop", exp_t.dropped, got_t.dropped);
        compare_field("total_count", exp_t.total, got_t.total);
        compare_field("distinct_count", exp_t.distinct, got_t.distinct);
        compare_field("top_value", exp_t.mode_value, got_t.mode_value);
        compare_field("top_times", exp_t.mode_times, got_t.mode_times);
      end
    end
  end

  // Result side backpressure
  initial begin : sink_ready
    int hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 99) < 15) begin
        hold = idle_cycles();
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [IN_VALUE_W-1:0] pool_pick();
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic test_directed();
    send_request(OP_QUERY, 32'h0000_0000);    // empty table, top still zero
    send_request(OP_RECORD, 32'h8000_0000);
    send_request(OP_RECORD, 32'h7FFF_FFFF);
    send_request(OP_RECORD, 32'h0000_0000);
    send_request(OP_RECORD, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h8000_0000);
    send_request(OP_RECORD, 32'h7FFF_FFFF);
    send_request(OP_RECORD, 32'h8000_0000);   // tie: top stays
    send_request(OP_RECORD, 32'h8000_0000);   // strictly greater: top moves
    send_request(OP_QUERY, 32'h0000_3039);    // absent
    send_request(OP_RECORD, 32'h5555_5555);
    send_request(OP_RECORD, 32'hAAAA_AAAA);
    send_request(OP_QUERY, 32'h5555_5555);
    send_request(OP_QUERY, 32'hAAAA_AAAA);
    send_request(OP_QUERY, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h7FFF_FFFF);
  endtask

  // Hold results off long enough that the core fills and stalls its input
  task automatic test_output_stall();
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) send_request($urandom_range(0, 3) == 0 ? OP_QUERY : OP_RECORD, pool_pick());
    idle_en = 1'b1;
  endtask

  task automatic test_random_mix(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_request(OP_RECORD, pool_pick());
      else if (r < 75) send_request(OP_RECORD, $urandom);
      else if (r < 92) send_request(OP_QUERY, pool_pick());
      else send_request(OP_QUERY, $urandom);
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    test_random_mix(count);
    idle_en = 1'b1;
  endtask

  // Append fresh values until no entry is left, then push past the edge
  task automatic test_table_full();
    while (tbl_used < TBL_DEPTH) begin
      if ($urandom_range(0, 9) == 0) send_request(OP_RECORD, pool_pick());
      else send_request(OP_RECORD, $urandom);
    end
    repeat (20) begin
      send_request(OP_RECORD, $urandom);
      send_request(OP_QUERY, tbl_value[$urandom_range(0, tbl_used - 1)]);
    end
  endtask

  task automatic test_random_full(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_request(OP_RECORD, tbl_value[$urandom_range(0, tbl_used - 1)]);
      else if (r < 65) send_request(OP_RECORD, pool_pick());
      else if (r < 80) send_request(OP_QUERY, tbl_value[$urandom_range(0, tbl_used - 1)]);
      else if (r < 90) send_request(OP_QUERY, $urandom);
      else send_request(OP_RECORD, $urandom);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    mismatch_count = 0;
    items_sent    = 0;
    tbl_used      = 0;
    records_total = '0;
    mode_value    = '0;
    mode_times    = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < 16; k++) value_pool[k] = $urandom_range(0, 15) - 8;
    for (int k = 16; k < POOL_SIZE; k++) value_pool[k] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_stall();
    test_random_mix(700);
    test_back_to_back(60);
    test_table_full();
    if (items_sent < ITEM_TARGET) test_random_full(ITEM_TARGET - items_sent);

    s_axis_tvalid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[value_frequency_counter_core] OK");
    end else begin
      $display("[value_frequency_counter_core] ERROR");
    end
    $finish;
  end

endmodule
